// ===== hw/rtl/bla_pkg.sv =====
// Shared types and constants for the block lag autocorrelator.
package bla_pkg;

    localparam int MAX_LAG_DEFAULT = 64;
    localparam int SAMPLE_W        = 16;
    localparam int PROD_W          = 2 * SAMPLE_W;
    localparam int CORR_W          = 38;
    localparam int LAG_IDX_W       = 6;
    localparam int CFG_W           = 7;
    localparam int SEEN_W          = 8;
    localparam int M_DATA_W        = ((LAG_IDX_W + CORR_W + 7) / 8) * 8;
    localparam int M_PAD_W         = M_DATA_W - LAG_IDX_W - CORR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic acc_clr;
    } mac_ctrl_t;

endpackage

// ===== hw/rtl/block_lag_autocorrelator.sv =====
// Top level of the block lag autocorrelator with its sequencer.
//
// Samples enter on the s_ channel, one request per sample, with s_tuser set
// on the first sample of a series. The user must write the lag count on the
// cfg_ channel only while the block is idle; the block does not enforce it.
// Zero counts as one and values above MAX_LAG count as MAX_LAG. Once 2N
// samples of a series have arrived, and after every further N samples, the
// block emits N requests on the m_ channel, lag 0 first and m_tlast on
// lag N-1. A sample that emits nothing is taken at once. A sample that
// emits keeps s_tready low until the result of the last lag is registered:
// one shared multiplier and accumulator runs N products per lag and then
// drains its pipeline. The first result appears once the products of lag 0
// have passed the read registers, the product register and the accumulator
// into the result register. If the receiver stalls, the result register
// holds and the multiplier waits at the end of the next lag; no result is
// dropped. Reset empties the pipeline, clears the sample count and sets the
// lag count to one; history contents are not cleared.
module block_lag_autocorrelator #(
    parameter int MAX_LAG = bla_pkg::MAX_LAG_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // sample[15:0]
    input  logic                          s_tuser,  // first
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bla_pkg::M_DATA_W-1:0]  m_tdata,  // lag_index[5:0], correlation[43:6]
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bla_pkg::CFG_W-1:0]     cfg_data
);

    localparam int PTR_W  = $clog2(2 * MAX_LAG);
    localparam int IDX_W  = $clog2(MAX_LAG + 1);
    localparam int SPAN_W = IDX_W + 1;

    bla_pkg::state_t    state_reg, state_next;
    bla_pkg::mac_ctrl_t ctrl;

    logic [bla_pkg::CFG_W-1:0]  lag_count_reg;
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [bla_pkg::SEEN_W-1:0] seen_reg, seen_next;
    logic [IDX_W-1:0]           n_reg, n_next;
    logic [IDX_W-1:0]           half_reg, half_next;
    logic [PTR_W-1:0]           base_reg, base_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           j_reg, j_next;

    logic                                 out_vld_reg, out_vld_next;
    logic [bla_pkg::LAG_IDX_W-1:0]        out_lag_reg, out_lag_next;
    logic signed [bla_pkg::CORR_W-1:0]    out_corr_reg, out_corr_next;
    logic                                 out_last_reg, out_last_next;

    logic [IDX_W-1:0]           n_eff;
    logic [SPAN_W-1:0]          span;
    logic [bla_pkg::SEEN_W-1:0] seen_base;
    logic [bla_pkg::SEEN_W-1:0] seen_inc;
    logic                       in_accept;
    logic                       emit;
    logic                       out_free;
    logic                       lag_done;
    logic                       block_done;
    logic [PTR_W-1:0]           new_ptr;
    logic [PTR_W-1:0]           rd_addr_a;
    logic [PTR_W-1:0]           rd_addr_b;
    logic signed [bla_pkg::CORR_W-1:0] acc;
    logic                       busy;

    always_comb begin
        if (lag_count_reg == '0) begin
            n_eff = IDX_W'(1);
        end else if (lag_count_reg > bla_pkg::CFG_W'(MAX_LAG)) begin
            n_eff = IDX_W'(MAX_LAG);
        end else begin
            n_eff = IDX_W'(lag_count_reg);
        end
    end

    assign span       = {n_eff, 1'b0};
    assign seen_base  = s_tuser ? '0 : seen_reg;
    assign seen_inc   = (seen_base == '1) ? seen_base : seen_base + 1'b1;
    assign emit       = seen_inc >= bla_pkg::SEEN_W'(span);
    assign in_accept  = s_tvalid & s_tready;
    assign out_free   = !out_vld_reg || m_tready;
    assign lag_done   = (j_reg == n_reg - 1'b1);
    assign block_done = (i_reg == n_reg - 1'b1);
    assign new_ptr    = wr_ptr_reg + 1'b1;
    assign rd_addr_a  = base_reg + PTR_W'(i_reg) + PTR_W'(j_reg);
    assign rd_addr_b  = base_reg + PTR_W'(half_reg) + PTR_W'(j_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bla_pkg::ST_IDLE: begin
                if (s_tvalid && emit) begin
                    state_next = bla_pkg::ST_MAC;
                end
            end
            bla_pkg::ST_MAC: begin
                if (lag_done) begin
                    state_next = bla_pkg::ST_DRAIN;
                end
            end
            bla_pkg::ST_DRAIN: begin
                if (!busy && out_free) begin
                    state_next = block_done ? bla_pkg::ST_IDLE : bla_pkg::ST_MAC;
                end
            end
            default: begin
                state_next = bla_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        ctrl          = '0;
        wr_ptr_next   = wr_ptr_reg;
        seen_next     = seen_reg;
        n_next        = n_reg;
        half_next     = half_reg;
        base_next     = base_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_lag_next  = out_lag_reg;
        out_corr_next = out_corr_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            bla_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (in_accept) begin
                    ctrl.wr_en  = 1'b1;
                    wr_ptr_next = new_ptr;
                    seen_next   = seen_inc;
                    if (emit) begin
                        seen_next    = bla_pkg::SEEN_W'(n_eff);
                        n_next       = n_eff;
                        half_next    = n_eff >> 1;
                        base_next    = new_ptr - PTR_W'(span) + 1'b1;
                        i_next       = '0;
                        j_next       = '0;
                        ctrl.acc_clr = 1'b1;
                    end
                end
            end
            bla_pkg::ST_MAC: begin
                ctrl.rd_en = 1'b1;
                j_next     = j_reg + 1'b1;
            end
            bla_pkg::ST_DRAIN: begin
                if (!busy && out_free) begin
                    out_vld_next  = 1'b1;
                    out_lag_next  = bla_pkg::LAG_IDX_W'(i_reg);
                    out_corr_next = acc;
                    out_last_next = block_done;
                    if (!block_done) begin
                        i_next       = i_reg + 1'b1;
                        j_next       = '0;
                        ctrl.acc_clr = 1'b1;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bla_pkg::ST_IDLE;
            lag_count_reg <= bla_pkg::CFG_W'(1);
            wr_ptr_reg    <= '0;
            seen_reg      <= '0;
            n_reg         <= IDX_W'(1);
            half_reg      <= '0;
            base_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                lag_count_reg <= cfg_data;
            end
            wr_ptr_reg  <= wr_ptr_next;
            seen_reg    <= seen_next;
            n_reg       <= n_next;
            half_reg    <= half_next;
            base_reg    <= base_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_lag_reg  <= out_lag_next;
        out_corr_reg <= out_corr_next;
        out_last_reg <= out_last_next;
    end

    bla_datapath #(
        .MAX_LAG (MAX_LAG),
        .PTR_W   (PTR_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .wr_addr   (new_ptr),
        .wr_data   (s_tdata),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .acc       (acc),
        .busy      (busy)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {{bla_pkg::M_PAD_W{1'b0}}, out_corr_reg, out_lag_reg};
    assign m_tlast   = out_last_reg;

endmodule

// ===== hw/rtl/bla_datapath.sv =====
// Sample history memory with a shared multiply-accumulate pipeline.
module bla_datapath #(
    parameter int MAX_LAG = bla_pkg::MAX_LAG_DEFAULT,
    parameter int PTR_W   = $clog2(2 * MAX_LAG)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bla_pkg::mac_ctrl_t                   ctrl,
    input  logic [PTR_W-1:0]                     wr_addr,
    input  logic signed [bla_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic [PTR_W-1:0]                     rd_addr_a,
    input  logic [PTR_W-1:0]                     rd_addr_b,
    output logic signed [bla_pkg::CORR_W-1:0]    acc,
    output logic                                 busy
);

    localparam int HIST_DEPTH = 2 * MAX_LAG;

    logic signed [bla_pkg::SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
    logic signed [bla_pkg::SAMPLE_W-1:0] rd_a_reg;
    logic signed [bla_pkg::SAMPLE_W-1:0] rd_b_reg;
    logic signed [bla_pkg::PROD_W-1:0]   prod_reg;
    logic signed [bla_pkg::CORR_W-1:0]   acc_reg;
    logic                                rd_vld_reg;
    logic                                prod_vld_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_a_reg <= hist_mem[rd_addr_a];
            rd_b_reg <= hist_mem[rd_addr_b];
        end
        prod_reg <= rd_a_reg * rd_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            rd_vld_reg   <= ctrl.rd_en;
            prod_vld_reg <= rd_vld_reg;
            if (ctrl.acc_clr) begin
                acc_reg <= '0;
            end else if (prod_vld_reg) begin
                acc_reg <= acc_reg + bla_pkg::CORR_W'(prod_reg);
            end
        end
    end

    assign acc  = acc_reg;
    assign busy = rd_vld_reg | prod_vld_reg;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the block lag autocorrelator, with a lag-sum predictor.
module testbench;

    localparam int LAG_CAP    = 64;
    localparam int HIST_LEN   = 128;
    localparam int IDLE_GAP   = 8;
    localparam int DRAIN_WAIT = 100;
    localparam int CYCLE_CAP  = 4000000;

    typedef struct {
        bit [bla_pkg::LAG_IDX_W-1:0] lag;
        bit [bla_pkg::CORR_W-1:0]    corr;
        bit                          last;
    } lag_result_t;

    class lag_sum_tracker;
        bit [bla_pkg::SAMPLE_W-1:0] history [HIST_LEN];
        bit [bla_pkg::SEEN_W-1:0]   seen;
        bit [bla_pkg::CFG_W-1:0]    lag_setting;
        lag_result_t                pending_lags [$];
        int                         mismatches;

        function new();
            foreach (history[k]) history[k] = '0;
            seen = '0;
            lag_setting = 7'd1;
            mismatches = 0;
        endfunction

        function void set_lags(bit [bla_pkg::CFG_W-1:0] value);
            lag_setting = value;
        endfunction

        function int pending();
            return pending_lags.size();
        endfunction

        function void note_sample(bit [bla_pkg::SAMPLE_W-1:0] smp, bit first);
            int n;
            int span;
            int half;
            longint acc;
            lag_result_t r;
            n = (lag_setting == 0) ? 1
                : ((lag_setting > LAG_CAP) ? LAG_CAP : int'(lag_setting));
            span = 2 * n;
            half = n / 2;
            if (first)
                seen = '0;
            for (int k = HIST_LEN - 1; k > 0; k--)
                history[k] = history[k - 1];
            history[0] = smp;
            if (seen != 8'hFF)
                seen++;
            if (seen < span)
                return;
            seen = bla_pkg::SEEN_W'(n);
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < n; j++)
                    acc += longint'($signed(history[span - 1 - i - j]))
                         * longint'($signed(history[span - 1 - half - j]));
                r.lag = bla_pkg::LAG_IDX_W'(i);
                r.corr = acc[bla_pkg::CORR_W-1:0];
                r.last = (i == n - 1);
                pending_lags.push_back(r);
            end
        endfunction

        function void check_result(bit [bla_pkg::LAG_IDX_W-1:0] lag,
                                   bit [bla_pkg::CORR_W-1:0] corr, bit last);
            lag_result_t want;
            if (pending_lags.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result request: lag %0d corr %0d last %0b",
                             lag, $signed(corr), last);
                return;
            end
            want = pending_lags.pop_front();
            if (want.lag !== lag || want.corr !== corr || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected lag %0d corr %0d last %0b, ",
                              "got lag %0d corr %0d last %0b"},
                             want.lag, $signed(want.corr), want.last,
                             lag, $signed(corr), last);
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b1;
    logic [bla_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bla_pkg::CFG_W-1:0]      cfg_data;

    lag_sum_tracker sb;
    int             burst_left = 0;
    int             cycles = 0;
    int             ready_mode = 0;
    int             ready_phase = 0;

    block_lag_autocorrelator #(.MAX_LAG(LAG_CAP)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[bla_pkg::LAG_IDX_W-1:0],
                            m_tdata[bla_pkg::LAG_IDX_W+bla_pkg::CORR_W-1:bla_pkg::LAG_IDX_W],
                            m_tlast);
    end

    // The receiver switches between always ready, random stalls and a fixed stall pattern.
    always @(negedge aclk) begin
        ready_phase++;
        if (ready_phase % 200 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (ready_phase % 8 < 5);
            default: m_tready <= $urandom_range(0, 1);
        endcase
    end

    function automatic bit [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input bit [15:0] smp, input bit first);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 2))
                @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tdata = smp;
        s_tuser = first;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(smp, first);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (IDLE_GAP) @(negedge aclk);
    endtask

    task automatic write_lags(input bit [bla_pkg::CFG_W-1:0] value);
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_lags(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        bit [15:0]               dir_samples [13];
        bit                      dir_first [13];
        bit [bla_pkg::CFG_W-1:0] phase_lags [8];
        int                      phase_items [8];
        int                      phase_restart [8];
        bit                      phase_fresh [8];
        bit                      first;

        dir_samples = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000,
                        16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h0002, 16'hFFFE};
        dir_first   = '{1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1, 1, 0};
        phase_lags    = '{7'd0, 7'd3, 7'd2, 7'd65, 7'd127, 7'd4, 7'd1, 7'd8};
        phase_items   = '{2, 6, 2, 128, 2, 2, 1, 4};
        phase_restart = '{2, 0, 0, 0, 0, 0, 0, 3};
        phase_fresh   = '{1, 1, 0, 1, 0, 0, 0, 0};
        phase_lags[7] = bla_pkg::CFG_W'($urandom_range(1, 16));

        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Reset lag count of one: extremes of the sample and short series.
        foreach (dir_samples[k])
            send_sample(dir_samples[k], dir_first[k]);
        wait_idle();

        // Phases that keep the series going across a register write test a mid-series change.
        foreach (phase_lags[p]) begin
            write_lags(phase_lags[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                if (k == 0)
                    first = phase_fresh[p] || $urandom_range(0, 3) == 0;
                else
                    first = (phase_restart[p] != 0)
                            && ($urandom_range(0, phase_restart[p] - 1) == 0);
                send_sample(pick_sample(), first);
            end
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== block_lag_autocorrelator.f =====
hw/rtl/bla_pkg.sv
hw/rtl/bla_datapath.sv
hw/rtl/block_lag_autocorrelator.sv
bench/testbench.sv
